// File: src/bcc_pkg.sv
// Package for the balance cascade controller: payload types, register indexes, helpers.
`default_nettype none

package bcc_pkg;

    // outer loop runs when the tick counter reaches this value
    localparam logic [3:0] SPEED_DIVIDE = 4'd10;

    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 32;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_CONTROL_ENABLE     = 3'd0,
        CFG_SPEED_GAIN_P       = 3'd1,
        CFG_SPEED_GAIN_I_DT    = 3'd2,
        CFG_PITCH_TARGET_LIMIT = 3'd3,
        CFG_TILT_GAIN_P        = 3'd4,
        CFG_TILT_GAIN_D        = 3'd5,
        CFG_CURRENT_LIMIT      = 3'd6,
        CFG_SHUTDOWN_ANGLE     = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic signed [15:0] pitch;
        logic signed [15:0] pitch_vel;
        logic signed [15:0] wheel_speed;
    } t_in;

    typedef struct packed {
        logic signed [15:0] motor_current;
        logic signed [15:0] current_unclamped;
        logic signed [15:0] current_p_term;
        logic signed [15:0] current_d_term;
        logic signed [15:0] pitch_target_out;
        logic signed [15:0] speed_p_term;
        logic signed [15:0] speed_int_term;
        logic signed [15:0] speed_measured;
        logic               tipped_over;
        logic               speed_updated;
    } t_out;

    function automatic logic signed [15:0] sat16(input logic signed [31:0] v);
        if (v > 32'sd32767) begin
            return 16'sh7fff;
        end else if (v < -32'sd32768) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
        if (v > 43'sh000_7fff_ffff) begin
            return 32'sh7fff_ffff;
        end else if (v < -43'sh000_8000_0000) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // symmetric clamp to +-lim, lim is a 15-bit magnitude
    function automatic logic signed [15:0] clamp_lim(input logic signed [31:0] v,
                                                     input logic [14:0] lim);
        logic signed [31:0] hi;
        logic signed [31:0] lo;
        hi = signed'({17'b0, lim});
        lo = -hi;
        if (v > hi) begin
            return hi[15:0];
        end else if (v < lo) begin
            return lo[15:0];
        end
        return v[15:0];
    endfunction

endpackage

`default_nettype wire

// File: src/balance_cascade_controller.sv
// Cascaded speed PI / pitch PD balance controller built around one shared multiplier.
`default_nettype none

// Each control tick is one input transaction. With control_enable set, a tick runs
// through an eight-step sequencer that reuses a single signed 32x17 multiplier four
// times (speed P, speed I, tilt P, tilt D) with rounding, saturation and clamp steps
// in between; the result is registered in S_SUM and no new tick is taken before the
// return to S_IDLE. With control_enable clear the result is ready the cycle after
// acceptance. The input is ready only when the sequencer is idle and the output register
// is free or being drained. Gains are Q8.24, angles and currents Q4.12; products round
// to nearest (ties up) and all result fields saturate to 16 bits. The outer speed loop
// runs on every eleventh enabled tick. Write configuration only while the block is idle;
// writing control_enable also clears the speed integral.
module balance_cascade_controller (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire bcc_pkg::t_in                   i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output bcc_pkg::t_out                       o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [bcc_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [bcc_pkg::CfgDataW-1:0]   i_cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_SP,
        S_MUL_I,
        S_INTEG,
        S_SI,
        S_PT,
        S_MUL_P,
        S_MUL_D,
        S_SUM
    } t_state;

    t_state r_state;

    // configuration
    logic               r_enable;
    logic signed [31:0] r_gain_sp;
    logic signed [31:0] r_gain_si;
    logic [14:0]        r_pt_limit;
    logic signed [31:0] r_gain_tp;
    logic signed [31:0] r_gain_td;
    logic [14:0]        r_cur_limit;
    logic [14:0]        r_shutdown;

    // loop state
    logic [3:0]         r_tick;
    logic signed [15:0] r_held;
    logic signed [15:0] r_pt;
    logic signed [31:0] r_integ;

    // per-transaction working registers
    logic signed [15:0] r_pitch;
    logic signed [15:0] r_rate;
    logic               r_upd;
    logic               r_tipped;
    logic signed [48:0] r_prod;
    logic signed [29:0] r_sp;
    logic signed [15:0] r_si;
    logic signed [24:0] r_cp;

    logic               r_out_valid;
    bcc_pkg::t_out      r_out;

    // shared multiplier
    logic signed [31:0] w_op_a;
    logic signed [16:0] w_op_b;
    logic signed [48:0] w_prod;

    logic signed [16:0] w_err;
    logic signed [16:0] w_perr;
    logic signed [16:0] w_neg_rate;
    logic signed [16:0] w_abs_pitch;
    logic               w_tipped;
    logic               w_accept;
    bcc_pkg::t_out      w_idle_out;

    logic signed [48:0] w_rnd7;
    logic signed [48:0] w_rnd19;
    logic signed [48:0] w_rnd21;
    logic signed [48:0] w_rnd24;
    logic signed [42:0] w_isum;
    logic signed [32:0] w_irnd;
    logic signed [29:0] w_cd_w;
    logic signed [31:0] w_sum;
    logic signed [31:0] w_cd;

    assign w_accept    = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // error = held speed, except the negation of -32768 saturates
    assign w_err      = (r_held == 16'sh8000) ? -17'sd32767 : 17'(r_held);
    assign w_perr     = 17'(r_pt) - 17'(r_pitch);
    assign w_neg_rate = -17'(r_rate);

    assign w_abs_pitch = i_in_data.pitch[15] ? -17'(i_in_data.pitch) : 17'(i_in_data.pitch);
    assign w_tipped    = w_abs_pitch > signed'({2'b0, r_shutdown});

    // result of a tick taken while the loops are off
    always_comb begin
        w_idle_out = '0;
        w_idle_out.speed_measured = bcc_pkg::sat16(-32'(i_in_data.wheel_speed));
    end

    always_comb begin
        case (r_state)
            S_MUL_I: begin
                w_op_a = r_gain_si;
                w_op_b = w_err;
            end
            S_MUL_P: begin
                w_op_a = r_gain_tp;
                w_op_b = w_perr;
            end
            S_MUL_D: begin
                w_op_a = r_gain_td;
                w_op_b = w_neg_rate;
            end
            default: begin
                w_op_a = r_gain_sp;
                w_op_b = w_err;
            end
        endcase
    end

    assign w_prod = 49'(w_op_a) * 49'(w_op_b);

    // round to nearest, ties up, then arithmetic shift
    assign w_rnd7  = r_prod + 49'sh40;
    assign w_rnd19 = r_prod + 49'sh4_0000;
    assign w_rnd21 = r_prod + 49'sh10_0000;
    assign w_rnd24 = r_prod + 49'sh80_0000;

    assign w_isum = 43'(r_integ) + 43'(signed'(w_rnd7[48:7]));
    assign w_irnd = 33'(r_integ) + 33'sh800;

    assign w_cd_w = 30'(signed'(w_rnd21[48:21]));
    assign w_cd   = 32'(w_cd_w);
    assign w_sum  = 32'(r_cp) + w_cd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_enable    <= 1'b0;
            r_gain_sp   <= 32'sd10066;
            r_gain_si   <= 32'sd0;
            r_pt_limit  <= 15'd328;
            r_gain_tp   <= 32'sd161061274;
            r_gain_td   <= 32'sd4362076;
            r_cur_limit <= 15'd4915;
            r_shutdown  <= 15'd8192;
            r_tick      <= 4'd0;
            r_held      <= 16'sd0;
            r_pt        <= 16'sd0;
            r_integ     <= 32'sd0;
            r_upd       <= 1'b0;
            r_tipped    <= 1'b0;
        end else begin
            // a disabled tick refills the output in the same cycle it drains
            if (r_out_valid && i_out_ready && !(w_accept && !r_enable)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_pitch  <= i_in_data.pitch;
                        r_rate   <= i_in_data.pitch_vel;
                        r_tipped <= w_tipped;
                        if (!r_enable) begin
                            r_tick      <= 4'd0;
                            r_pt        <= 16'sd0;
                            r_integ     <= 32'sd0;
                            r_held      <= i_in_data.wheel_speed;
                            r_out       <= w_idle_out;
                            r_out_valid <= 1'b1;
                        end else begin
                            if (r_tick >= bcc_pkg::SPEED_DIVIDE) begin
                                r_tick <= 4'd0;
                                r_upd  <= 1'b1;
                                r_held <= i_in_data.wheel_speed;
                            end else begin
                                r_tick <= r_tick + 4'd1;
                                r_upd  <= 1'b0;
                            end
                            r_state <= S_MUL_SP;
                        end
                    end
                end
                S_MUL_SP: begin
                    r_prod  <= w_prod;
                    r_state <= S_MUL_I;
                end
                S_MUL_I: begin
                    r_sp    <= 30'(w_rnd19[48:19]);
                    r_prod  <= w_prod;
                    r_state <= S_INTEG;
                end
                S_INTEG: begin
                    if (r_upd) begin
                        if (r_gain_si != 32'sd0) begin
                            r_integ <= bcc_pkg::sat32(w_isum);
                        end else begin
                            r_integ <= 32'sd0;
                        end
                    end
                    r_state <= S_SI;
                end
                S_SI: begin
                    r_si    <= bcc_pkg::clamp_lim(32'(signed'(w_irnd[32:12])), r_pt_limit);
                    r_state <= S_PT;
                end
                S_PT: begin
                    if (r_upd) begin
                        r_pt <= bcc_pkg::clamp_lim(32'(r_sp) + 32'(r_si), r_pt_limit);
                    end
                    // a fall clears the integral after the outer loop has used it
                    if (r_tipped) begin
                        r_integ <= 32'sd0;
                    end
                    r_state <= S_MUL_P;
                end
                S_MUL_P: begin
                    r_prod  <= w_prod;
                    r_state <= S_MUL_D;
                end
                S_MUL_D: begin
                    r_cp    <= 25'(w_rnd24[48:24]);
                    r_prod  <= w_prod;
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    if (r_tipped) begin
                        r_out.motor_current     <= 16'sd0;
                        r_out.current_unclamped <= 16'sd0;
                        r_out.current_p_term    <= 16'sd0;
                        r_out.current_d_term    <= 16'sd0;
                    end else begin
                        r_out.motor_current     <= bcc_pkg::clamp_lim(w_sum, r_cur_limit);
                        r_out.current_unclamped <= bcc_pkg::sat16(w_sum);
                        r_out.current_p_term    <= bcc_pkg::sat16(32'(r_cp));
                        r_out.current_d_term    <= bcc_pkg::sat16(w_cd);
                    end
                    r_out.pitch_target_out <= r_pt;
                    r_out.speed_p_term     <= bcc_pkg::sat16(32'(r_sp));
                    r_out.speed_int_term   <= r_si;
                    r_out.speed_measured   <= bcc_pkg::sat16(-32'(r_held));
                    r_out.tipped_over      <= r_tipped;
                    r_out.speed_updated    <= r_upd;
                    r_out_valid            <= 1'b1;
                    r_state                <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (i_cfg_we) begin
                case (bcc_pkg::t_cfg_idx'(i_cfg_index))
                    bcc_pkg::CFG_CONTROL_ENABLE: begin
                        r_enable <= i_cfg_data[0];
                        r_integ  <= 32'sd0;
                    end
                    bcc_pkg::CFG_SPEED_GAIN_P:       r_gain_sp   <= signed'(i_cfg_data);
                    bcc_pkg::CFG_SPEED_GAIN_I_DT:    r_gain_si   <= signed'(i_cfg_data);
                    bcc_pkg::CFG_PITCH_TARGET_LIMIT: r_pt_limit  <= i_cfg_data[14:0];
                    bcc_pkg::CFG_TILT_GAIN_P:        r_gain_tp   <= signed'(i_cfg_data);
                    bcc_pkg::CFG_TILT_GAIN_D:        r_gain_td   <= signed'(i_cfg_data);
                    bcc_pkg::CFG_CURRENT_LIMIT:      r_cur_limit <= i_cfg_data[14:0];
                    bcc_pkg::CFG_SHUTDOWN_ANGLE:     r_shutdown  <= i_cfg_data[14:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire
